FILE: rtl/bmh_pkg.sv
// shared types and status codes for the bounded max-heap
`timescale 1ns / 1ps
`default_nettype none
package bmh_pkg;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_DISCARDED = 3'd4,
        ST_EXTRACTED = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        MODE_UPSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned SCORE_W = 32;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/bounded_max_heap_upsert.sv
// bounded max-heap of (id, score) entries with upsert and extract
`timescale 1ns / 1ps
`default_nettype none
// The heap sits in one memory with one write port and a registered read port, so
// each entry visit of the id scan takes a read state and a compare state. An upsert
// scans all held entries for its id, then sifts up with a write and a compare state
// per level; a full-heap newcomer scans for the minimum as well and may sift down
// afterwards. An extract reads the last entry and sifts down, with read, left-child,
// right-child, write and swap states per level. One item is in work at a time, and
// the finished word waits in an output register, so s_axis_tready returns as soon
// as that register is free to be loaded again.
module bounded_max_heap_upsert
    import bmh_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[0], seed_id[32:1], score_increment[64:33], zero pad [71:65]
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], taken_valid[3], taken_id[35:4], taken_score[67:36],
    // best_valid[68], best_id[100:69], best_score[132:101], fill_count[137:133],
    // zero pad [143:138]
    output logic [143:0]      m_axis_tdata
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_SRD    = 16'h0002,
        S_SCMP   = 16'h0004,
        S_MRD    = 16'h0008,
        S_MCMP   = 16'h0010,
        S_UPRD   = 16'h0020,
        S_UPCMP  = 16'h0040,
        S_UPWR   = 16'h0080,
        S_DNRD   = 16'h0100,
        S_DNL    = 16'h0200,
        S_DNR    = 16'h0400,
        S_DNWR   = 16'h0800,
        S_XLAST  = 16'h1000,
        S_XWAIT  = 16'h2000,
        S_ROOT   = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    entry_t mem [CAPACITY];
    entry_t rd_data;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    entry_t          wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;       // scan index / current position
    logic [CW-1:0] aux_reg, aux_next;       // minimum position / best child
    entry_t cur_reg, cur_next;              // entry being moved
    entry_t oth_reg, oth_next;              // left child or best child
    logic [SCORE_W-1:0] min_reg, min_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [SCORE_W-1:0] inc_reg, inc_next;
    logic down_reg, down_next;              // sift down follows sift up
    status_t st_reg, st_next;
    entry_t taken_reg, taken_next;
    logic tv_reg, tv_next;
    logic ov_reg, ov_next;
    logic [143:0] od_reg, od_next;

    logic [CW:0] lc, rc;
    logic [CW-1:0] par;
    logic [SCORE_W:0] sum;

    always_comb
    begin
        lc  = {idx_reg, 1'b1};
        rc  = {idx_reg, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
        par = (idx_reg - {{(CW-1){1'b0}}, 1'b1}) >> 1;
        sum = {1'b0, rd_data.score} + {1'b0, inc_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        aux_next   = aux_reg;
        cur_next   = cur_reg;
        oth_next   = oth_reg;
        min_next   = min_reg;
        id_next    = id_reg;
        inc_next   = inc_reg;
        down_next  = down_reg;
        st_next    = st_reg;
        taken_next = taken_reg;
        tv_next    = tv_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        raddr = idx_reg[AW-1:0];
        s_axis_tready = 1'b0;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = !ov_reg || m_axis_tready;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    id_next    = s_axis_tdata[32:1];
                    inc_next   = s_axis_tdata[64:33];
                    idx_next   = '0;
                    tv_next    = 1'b0;
                    taken_next = '0;
                    down_next  = 1'b0;
                    if (s_axis_tdata[0] == MODE_EXTRACT)
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            st_next    = ST_EXTRACTED;
                            state_next = S_XLAST;
                        end
                    end
                    else if (s_axis_tdata[64:33] == '0 || s_axis_tdata[64])
                    begin
                        st_next    = ST_IGNORED;
                        state_next = S_ROOT;
                    end
                    else
                        state_next = (count_reg == '0) ? S_MRD : S_SRD;
                end
            end
            S_SRD:
                state_next = S_SCMP;
            S_SCMP:
            begin
                if (rd_data.id == id_reg)
                begin
                    cur_next.id    = rd_data.id;
                    cur_next.score = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                    st_next        = ST_UPDATED;
                    state_next     = S_UPWR;
                end
                else if (idx_reg + 1'b1 == count_reg)
                    state_next = S_MRD;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                // new id: append or start minimum scan
                cur_next = '{id: id_reg, score: inc_reg};
                if (count_reg != CW'(CAPACITY))
                begin
                    idx_next   = count_reg;
                    count_next = count_reg + 1'b1;
                    st_next    = ST_INSERTED;
                    state_next = S_UPWR;
                end
                else
                begin
                    raddr      = '0;
                    idx_next   = '0;
                    aux_next   = '0;
                    min_next   = '1;
                    state_next = S_MCMP;
                end
            end
            S_MCMP:
            begin
                if (rd_data.score < min_reg || idx_reg == '0)
                begin
                    min_next = rd_data.score;
                    aux_next = idx_reg;
                end
                if (idx_reg + 1'b1 != count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr    = AW'(idx_reg + 1'b1);
                end
                else
                begin
                    if (rd_data.score < min_reg || idx_reg == '0)
                        idx_next = idx_reg;
                    else
                        idx_next = aux_reg;
                    if (inc_reg > ((rd_data.score < min_reg || idx_reg == '0)
                                   ? rd_data.score : min_reg))
                    begin
                        st_next    = ST_REPLACED;
                        down_next  = 1'b1;
                        state_next = S_UPWR;
                    end
                    else
                    begin
                        st_next    = ST_DISCARDED;
                        state_next = S_ROOT;
                    end
                end
            end
            S_UPWR:
            begin
                // cur sits at idx; write it, then look at the parent
                we       = 1'b1;
                aux_next = idx_reg;
                if (idx_reg == '0)
                    state_next = down_reg ? S_DNRD : S_ROOT;
                else
                begin
                    raddr      = par[AW-1:0];
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (cur_reg.score > rd_data.score)
                begin
                    // swap with parent
                    we       = 1'b1;
                    wdata    = rd_data;
                    idx_next = par;
                    state_next = S_UPWR;
                end
                else
                begin
                    idx_next   = aux_reg;
                    state_next = down_reg ? S_DNRD : S_ROOT;
                end
            end
            S_UPRD:
                state_next = S_UPCMP;
            S_XLAST:
            begin
                raddr      = '0;
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                tv_next    = 1'b1;
                taken_next = rd_data;
                count_next = count_reg - 1'b1;
                idx_next   = '0;
                raddr      = AW'(count_reg - 1'b1);
                state_next = S_DNWR;
                down_next  = 1'b1;
                // S_DNWR with down set writes the last entry into the root
                aux_next   = '1;
            end
            S_DNRD:
            begin
                // read the entry now at idx (replacement order keeps position)
                down_next  = 1'b0;
                state_next = S_DNL;
                if (lc >= {1'b0, count_reg})
                    state_next = S_ROOT;
                else
                    raddr = AW'(idx_reg);
            end
            S_DNL:
            begin
                cur_next = rd_data;
                raddr    = AW'(lc);
                state_next = S_DNR;
            end
            S_DNR:
            begin
                oth_next = rd_data;
                aux_next = CW'(lc);
                raddr    = AW'(rc);
                state_next = S_DNWR;
            end
            S_DNWR:
            begin
                if (down_reg)
                begin
                    // extract: move last entry into the root
                    down_next = 1'b0;
                    if (count_reg == '0)
                        state_next = S_ROOT;
                    else
                    begin
                        we       = 1'b1;
                        waddr    = '0;
                        wdata    = rd_data;
                        state_next = S_DNRD;
                    end
                end
                else
                begin
                    entry_t big;
                    logic [CW-1:0] bpos;
                    big  = cur_reg;
                    bpos = idx_reg;
                    if (oth_reg.score > big.score)
                    begin
                        big  = oth_reg;
                        bpos = aux_reg;
                    end
                    if (rc < {1'b0, count_reg} && rd_data.score > big.score)
                    begin
                        big  = rd_data;
                        bpos = CW'(rc);
                    end
                    if (bpos == idx_reg)
                        state_next = S_ROOT;
                    else
                    begin
                        we    = 1'b1;
                        wdata = big;
                        oth_next = big;
                        aux_next = bpos;
                        idx_next = bpos;
                        state_next = S_UPRD;
                        down_next  = 1'b1;
                    end
                end
            end
            S_ROOT:
            begin
                raddr      = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // keep the root on the read port while the output is busy
                raddr = '0;
                if (!ov_reg || m_axis_tready)
                begin
                    od_next = '0;
                    od_next[2:0]     = st_reg;
                    od_next[3]       = tv_reg;
                    od_next[35:4]    = taken_reg.id;
                    od_next[67:36]   = taken_reg.score;
                    od_next[68]      = count_reg != '0;
                    od_next[100:69]  = (count_reg != '0) ? rd_data.id : '0;
                    od_next[132:101] = (count_reg != '0) ? rd_data.score : '0;
                    od_next[137:133] = 5'(count_reg);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        // sift-down swap: after writing the child into the parent slot,
        // write the moving entry into the child slot (routed through S_UPRD)
        if (state_reg == S_UPRD && down_reg)
        begin
            we         = 1'b1;
            waddr      = idx_reg[AW-1:0];
            wdata      = cur_reg;
            down_next  = 1'b0;
            state_next = S_DNRD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        aux_reg   <= aux_next;
        cur_reg   <= cur_next;
        oth_reg   <= oth_next;
        min_reg   <= min_next;
        id_reg    <= id_next;
        inc_reg   <= inc_next;
        down_reg  <= down_next;
        st_reg    <= st_next;
        taken_reg <= taken_next;
        tv_reg    <= tv_next;
        od_reg    <= od_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (m_axis_tdata[68] == (m_axis_tdata[137:133] != 5'd0)))
        else $error("best flag disagrees with fill count");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while an item is in work");

endmodule
`default_nettype wire
